// ===== rtl/msps_pkg.sv =====
package msps_pkg;

  // width of every word field on the stream ports
  localparam int OUT_BITS = 32;

  // command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic fetch_load;  // refill cached top from ram read data
  } msps_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic need_fetch;  // pending command is a pop that must refill the top
  } msps_stat_t;

endpackage

// ===== rtl/msps_ram.sv =====
module msps_ram import msps_pkg::*; #(
  parameter int WIDTH     = 64,
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/msps_ctrl.sv =====
module msps_ctrl import msps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  msps_stat_t stat,
  output msps_ctrl_t ctrl
);

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free        = !out_valid || out_ready;
  assign in_ready        = (state == S_IDLE) && out_free;
  assign ctrl.accept     = in_valid && in_ready;
  assign ctrl.fetch_load = (state == S_FETCH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctrl.accept) begin
            if (stat.need_fetch) begin
              state <= S_FETCH;
              if (out_ready) begin
                out_valid <= 1'b0;
              end
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_FETCH: begin
          if (ctrl.fetch_load) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/msps_dp.sv =====
module msps_dp import msps_pkg::*; #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  msps_ctrl_t          ctrl,
  output msps_stat_t          stat,
  input  logic [1:0]          command,
  input  logic [OUT_BITS-1:0] value,
  output logic [OUT_BITS-1:0] top_value,
  output logic [OUT_BITS-1:0] min_value,
  output logic                is_empty,
  output logic [1:0]          status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 2 * WORD_BITS;

  logic [CW-1:0]        count, count_next;
  logic [WORD_BITS-1:0] top_val, top_val_next;
  logic [WORD_BITS-1:0] top_min, top_min_next;
  logic [CW-1:0]        count_m1, count_m2;
  logic                 is_zero, is_one, is_full;
  logic [WORD_BITS-1:0] in_word, push_min;
  logic                 wr_en, rd_en;
  logic [EW-1:0]        rd_data;
  logic                 out_load;
  logic [WORD_BITS-1:0] out_val_next, out_min_next;
  logic                 out_empty_next;
  logic [1:0]           out_status_next;

  assign is_zero  = (count == '0);
  assign is_one   = (count == CW'(1));
  assign is_full  = (count == CW'(DEPTH));
  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign in_word  = value[WORD_BITS-1:0];
  assign push_min = (!is_zero && ($signed(top_min) < $signed(in_word))) ? top_min : in_word;

  assign stat.need_fetch = (command == CMD_POP) && !is_zero && !is_one;

  // entries below the cached top live in ram
  msps_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_m1[AW-1:0]),
    .wr_data ({top_min, top_val}),
    .rd_en   (rd_en),
    .rd_addr (count_m2[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    count_next      = count;
    top_val_next    = top_val;
    top_min_next    = top_min;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    out_load        = 1'b0;
    out_val_next    = top_val;
    out_min_next    = top_min;
    out_empty_next  = is_zero;
    out_status_next = STAT_OK;
    if (ctrl.accept) begin
      case (command)
        CMD_PUSH: begin
          out_load = 1'b1;
          if (is_full) begin
            out_status_next = STAT_OVERFLOW;
          end else begin
            wr_en          = !is_zero;
            count_next     = count + CW'(1);
            top_val_next   = in_word;
            top_min_next   = push_min;
            out_val_next   = in_word;
            out_min_next   = push_min;
            out_empty_next = 1'b0;
          end
        end
        CMD_POP: begin
          if (is_zero) begin
            out_load        = 1'b1;
            out_status_next = STAT_UNDERFLOW;
          end else if (is_one) begin
            out_load       = 1'b1;
            count_next     = '0;
            out_empty_next = 1'b1;
          end else begin
            rd_en      = 1'b1;
            count_next = count_m1;
          end
        end
        default: begin
          out_load = 1'b1;
          if (is_zero) begin
            out_status_next = STAT_UNDERFLOW;
          end
        end
      endcase
    end else if (ctrl.fetch_load) begin
      out_load       = 1'b1;
      top_val_next   = rd_data[WORD_BITS-1:0];
      top_min_next   = rd_data[EW-1:WORD_BITS];
      out_val_next   = rd_data[WORD_BITS-1:0];
      out_min_next   = rd_data[EW-1:WORD_BITS];
      out_empty_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top_val <= top_val_next;
    top_min <= top_min_next;
    if (out_load) begin
      top_value <= out_empty_next ? '0 : OUT_BITS'($signed(out_val_next));
      min_value <= out_empty_next ? '0 : OUT_BITS'($signed(out_min_next));
      is_empty  <= out_empty_next;
      status    <= out_status_next;
    end
  end

endmodule

// ===== rtl/min_stack_pair_store_core.sv =====
// last-in first-out stack of signed words that also reports the smallest
// value held. every command beat (push, pop, peek) gives exactly one result
// beat with the top value, the current minimum, an empty flag and a status.
// each entry keeps its value with the running minimum at push time, so the
// minimum after a pop is simply the minimum stored with the new top. the top
// entry is cached in registers and the entries below it sit in a
// simple dual-port ram with registered read. push, peek and a pop from a
// single entry or from an empty stack need no ram read; a pop with two
// or more entries also passes through a fetch state for the ram read that
// refills the cached top. push to a full stack reports overflow and is
// dropped; pop or peek on an empty stack reports underflow and changes
// nothing; unused command code 3 acts as peek. only the low WORD_BITS bits of
// value are used, and results are sign-extended from WORD_BITS. results are
// zero when the stack is empty. the ram needs no clearing after reset.
module min_stack_pair_store_core import msps_pkg::*; #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // command[1:0], value[33:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // top_value[31:0], min_value[63:32],
                                      // is_empty[64], status[66:65], zero pad
);

  msps_ctrl_t          ctrl;
  msps_stat_t          stat;
  logic [OUT_BITS-1:0] top_value;
  logic [OUT_BITS-1:0] min_value;
  logic                is_empty;
  logic [1:0]          status;

  // sequencing: accept, optional ram refill, result beat hand-off
  msps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // entry count, cached top, ram and result register
  msps_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .command   (s_axis_tdata[1:0]),
    .value     (s_axis_tdata[33:2]),
    .top_value (top_value),
    .min_value (min_value),
    .is_empty  (is_empty),
    .status    (status)
  );

  assign m_axis_tdata = {5'd0, status, is_empty, min_value, top_value};

endmodule

// ===== test/msps_result_checker.sv =====
`timescale 1ns / 100ps

module msps_result_checker import msps_pkg::*; #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  logic [39:0] cmd_data,   // command[1:0], value[33:2], zero pad
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [71:0] res_data,   // top_value[31:0], min_value[63:32],
                                  // is_empty[64], status[66:65], zero pad
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          overflow_count,
  output int          underflow_count,
  output int          peak_depth
);

  typedef struct packed {
    logic signed [OUT_BITS-1:0] top_value;
    logic signed [OUT_BITS-1:0] min_value;
    logic                       is_empty;
    logic [1:0]                 status;
  } stack_view_t;

  // shadow stack: value and running minimum per entry
  logic signed [OUT_BITS-1:0] held_value [DEPTH];
  logic signed [OUT_BITS-1:0] held_min   [DEPTH];
  int          held_count = 0;
  stack_view_t due_views [$];

  int errors     = 0;
  int results    = 0;
  int overflows  = 0;
  int underflows = 0;
  int deepest    = 0;

  // low WORD_BITS of the raw word, sign-extended
  function automatic logic signed [OUT_BITS-1:0] as_word(input logic [OUT_BITS-1:0] raw);
    logic [OUT_BITS-1:0] lifted;
    lifted = raw << (OUT_BITS - WORD_BITS);
    return $signed(lifted) >>> (OUT_BITS - WORD_BITS);
  endfunction

  // apply one command to the shadow stack, return the view after it
  function automatic stack_view_t stack_outcome(input logic [1:0] cmd,
                                                input logic [OUT_BITS-1:0] raw);
    stack_view_t view;
    logic signed [OUT_BITS-1:0] word;
    logic signed [OUT_BITS-1:0] lowest;
    view.status = STAT_OK;
    case (cmd)
      CMD_PUSH: begin
        if (held_count >= DEPTH) begin
          view.status = STAT_OVERFLOW;
        end else begin
          word   = as_word(raw);
          lowest = word;
          if (held_count > 0 && held_min[held_count-1] < word)
            lowest = held_min[held_count-1];
          held_value[held_count] = word;
          held_min[held_count]   = lowest;
          held_count++;
        end
      end
      CMD_POP: begin
        if (held_count == 0) view.status = STAT_UNDERFLOW;
        else held_count--;
      end
      default: begin
        // peek and the spare code
        if (held_count == 0) view.status = STAT_UNDERFLOW;
      end
    endcase
    if (held_count == 0) begin
      view.top_value = '0;
      view.min_value = '0;
      view.is_empty  = 1'b1;
    end else begin
      view.top_value = held_value[held_count-1];
      view.min_value = held_min[held_count-1];
      view.is_empty  = 1'b0;
    end
    return view;
  endfunction

  always @(posedge clk) begin : watch
    stack_view_t want;
    stack_view_t got;
    if (rst) begin
      held_count = 0;
      due_views.delete();
    end else begin
      if (cmd_valid && cmd_ready) begin
        due_views.push_back(stack_outcome(cmd_data[1:0], cmd_data[33:2]));
        if (held_count > deepest) deepest = held_count;
      end
      if (res_valid && res_ready) begin
        got.top_value = res_data[31:0];
        got.min_value = res_data[63:32];
        got.is_empty  = res_data[64];
        got.status    = res_data[66:65];
        if (due_views.size() == 0) begin
          $error("result beat with no command outstanding");
          errors++;
        end else begin
          want = due_views.pop_front();
          results++;
          if (want.status == STAT_OVERFLOW) overflows++;
          if (want.status == STAT_UNDERFLOW) underflows++;
          if (got.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
            errors++;
          end
          if (got.min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
            errors++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
        end
      end
    end
    fail_count      <= errors;
    pending_count   <= due_views.size();
    result_count    <= results;
    overflow_count  <= overflows;
    underflow_count <= underflows;
    peak_depth      <= deepest;
  end

endmodule

// ===== test/tb_min_stack_pair_store_core.sv =====
`timescale 1ns / 100ps

module tb_min_stack_pair_store_core;
  import msps_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;

  // rough size of the random part, not a quota
  localparam int RANDOM_ITEMS = 800;
  // per-beat idle draw on both sides
  localparam int IDLE_MAX = 18;
  // receiver hold-off used to back the block up
  localparam int LONG_HOLD = 400;

  // unused command code, behaves like a peek
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // command[1:0], value[33:2], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // top_value[31:0], min_value[63:32],
                                     // is_empty[64], status[66:65], zero pad

  int fail_count;
  int pending_count;
  int result_count;
  int overflow_count;
  int underflow_count;
  int peak_depth;

  // depth as the stimulus sees it, only used to steer the sequences
  int stack_depth = 0;
  int pushes      = 0;
  int pops        = 0;
  int peeks       = 0;
  // when set the sender offers beats back to back
  bit sender_rush = 1'b0;

  min_stack_pair_store_core #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // watches both channels, predicts every result and counts mismatches
  msps_result_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) result_check (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (s_axis_tvalid),
    .cmd_ready       (s_axis_tready),
    .cmd_data        (s_axis_tdata),
    .res_valid       (m_axis_tvalid),
    .res_ready       (m_axis_tready),
    .res_data        (m_axis_tdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .result_count    (result_count),
    .overflow_count  (overflow_count),
    .underflow_count (underflow_count),
    .peak_depth      (peak_depth)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("FAIL min_stack_pair_store_core");
    $finish;
  end

  // offer one command beat and wait until it is taken; tvalid stays high
  // across back-to-back beats so it is never dropped and raised in one step
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] word);
    int gap;
    gap = sender_rush ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, word, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (cmd)
      CMD_PUSH: begin
        pushes++;
        if (stack_depth < DEPTH) stack_depth++;
      end
      CMD_POP: begin
        pops++;
        if (stack_depth > 0) stack_depth--;
      end
      default: begin
        peeks++;
      end
    endcase
  endtask

  // push data: extremes, values near them, small signed values, full random
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 63) - 32;
      3:       return 32'h8000_0000 + $urandom_range(0, 15);
      4:       return 32'h7FFF_FFFF - $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // result side: random stall per beat, idle-free stretches every so often,
  // and two long hold-offs so the block fills and pushes back on its input
  initial begin : result_sink
    int  stall;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 100 || taken == 600) stall = LONG_HOLD;
      else stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : command_source
    int sent;
    int run_len;
    int push_pct;
    int pick;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow on an empty stack for every non-push code
    send_command(CMD_PEEK,  $urandom());
    send_command(CMD_POP,   $urandom());
    send_command(CMD_SPARE, $urandom());
    // pushes through the word extremes, the minimum drops then holds
    send_command(CMD_PUSH,  32'h0000_0000);
    send_command(CMD_PUSH,  32'h7FFF_FFFF);
    send_command(CMD_PUSH,  32'h8000_0000);
    send_command(CMD_PUSH,  32'hFFFF_FFFF);
    send_command(CMD_PUSH,  32'h0000_0005);
    send_command(CMD_PEEK,  $urandom());
    send_command(CMD_SPARE, $urandom());
    // pops bring the older minimum back once the most negative entry goes
    send_command(CMD_POP,   $urandom());
    send_command(CMD_POP,   $urandom());
    send_command(CMD_POP,   $urandom());
    send_command(CMD_PUSH,  32'hAAAA_AAAA);
    send_command(CMD_PUSH,  32'h5555_5555);
    send_command(CMD_PUSH,  32'h8000_0000);
    while (stack_depth > 0) send_command(CMD_POP, $urandom());
    send_command(CMD_POP,   $urandom());

    // random runs with differing push bias: growth, churn near empty, drain
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      sender_rush = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          send_command(CMD_PUSH, pick_word());
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 7) send_command(CMD_POP, $urandom());
          else if (pick < 9) send_command(CMD_PEEK, $urandom());
          else send_command(CMD_SPARE, $urandom());
        end
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the checker register the last accept before draining
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d commands: %0d push, %0d pop, %0d peek or spare code",
             pushes + pops + peeks, pushes, pops, peeks);
    $display("%0d results checked, %0d overflow, %0d underflow, depth reached %0d of %0d",
             result_count, overflow_count, underflow_count, peak_depth, DEPTH);
    if (fail_count == 0) begin
      $display("PASS min_stack_pair_store_core");
    end else begin
      $display("FAIL min_stack_pair_store_core");
    end
    $finish;
  end

endmodule
